// ===== rtl/core/sle_pkg.sv =====
package sle_pkg;

  // Default number of list cells.
  localparam int unsigned SleDepth = 16;

  // Field widths of the request and result channels.
  localparam int unsigned OpW     = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SEARCH = 3'd2,
    OP_POP    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_MISS  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Command broadcast to every cell for one accepted request.
  typedef struct packed {
    logic                     insert;
    logic                     remove;
    logic                     pop;
    logic                     clear;
    logic signed [ValueW-1:0] key;
  } cmd_t;

  // What a cell shows to its neighbors and to the top level.
  typedef struct packed {
    logic signed [ValueW-1:0] entry;
    logic                     valid;
    logic                     place;  // Empty or larger than the key.
    logic                     eq;     // Holds a value equal to the key.
  } link_t;

endpackage

// ===== rtl/core/sle_if.sv =====
interface sle_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [sle_pkg::OpW-1:0]       operation;
  logic signed [sle_pkg::ValueW-1:0]    value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sle_res_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic signed [sle_pkg::ValueW-1:0]    minimum;
  logic        [sle_pkg::CountW-1:0]    count;
  logic                                 empty_res;
  logic        [sle_pkg::StatusW-1:0]   status;

  modport source (output valid, output found, output minimum, output count,
                  output empty_res, output status, input ready);
  modport sink   (input valid, input found, input minimum, input count,
                  input empty_res, input status, output ready);
endinterface

// ===== rtl/core/sorted_list_engine_top.sv =====
// Sorted list engine: keeps up to DEPTH signed 32-bit values in ascending
// order in a row of cells, each holding one value. A request is accepted in
// every cycle in which the result register is empty or its result is being
// taken; every cell compares its value against the request key in parallel
// and shifts in from a neighbor in the same cycle, so the result of a request
// appears in the result register on the next cycle. The result shows the
// list state after the request: minimum, count, empty flag, plus found and
// status for the request itself.
module sorted_list_engine_top #(
  parameter int unsigned DEPTH = sle_pkg::SleDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sle_req_if.sink       req_i,
  sle_res_if.source     res_o
);
  import sle_pkg::*;

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  link_t                links [DEPTH];
  link_t                boundary;
  cmd_t                 cmd;
  logic [DEPTH-1:0]     eq_vec;
  logic                 accept;
  logic                 found;
  logic                 full;
  logic                 found_d, found_q;
  status_e              status_d, status_q;
  logic                 res_valid_q;
  logic [OccW-1:0]      occ_q, occ_d;

  assign boundary = '{entry: '0, valid: 1'b0, place: 1'b0, eq: 1'b0};

  // Handshake: accept whenever the result slot is free or being drained.
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Gather the per-cell match flags.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq_vec[i] = links[i].eq;
    end
  end
  assign found = |eq_vec;
  assign full  = links[DEPTH-1].valid;

  // Decode the request into the command broadcast to the cells.
  always_comb begin
    cmd.insert = 1'b0;
    cmd.remove = 1'b0;
    cmd.pop    = 1'b0;
    cmd.clear  = 1'b0;
    cmd.key    = req_i.value;
    found_d    = 1'b0;
    status_d   = ST_OK;
    case (req_i.operation)
      OP_INSERT: begin
        cmd.insert = accept && !full;
        status_d   = full ? ST_FULL : ST_OK;
      end
      OP_REMOVE: begin
        cmd.remove = accept && found;
        found_d    = found;
        status_d   = found ? ST_OK : ST_MISS;
      end
      OP_SEARCH: begin
        found_d  = found;
        status_d = found ? ST_OK : ST_MISS;
      end
      OP_POP: begin
        cmd.pop  = accept && links[0].valid;
        status_d = links[0].valid ? ST_OK : ST_EMPTY;
      end
      OP_CLEAR: begin
        cmd.clear = accept;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Row of cells, each linked to both neighbors.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    link_t left_l;
    link_t right_l;
    if (g == 0) begin : g_first
      assign left_l = boundary;
    end else begin : g_mid_l
      assign left_l = links[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_l = boundary;
    end else begin : g_mid_r
      assign right_l = links[g+1];
    end
    sle_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  (left_l),
      .right_i (right_l),
      .cell_o  (links[g])
    );
  end

  // Occupancy counter follows the cell activity.
  always_comb begin
    occ_d = occ_q;
    if (cmd.clear) begin
      occ_d = '0;
    end else if (cmd.insert) begin
      occ_d = occ_q + OccW'(1);
    end else if (cmd.remove || cmd.pop) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      res_valid_q <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      occ_q <= occ_d;
      if (accept) begin
        res_valid_q <= 1'b1;
        found_q     <= found_d;
        status_q    <= status_d;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // The list cannot change while a result waits, so state fields read live.
  assign res_o.valid     = res_valid_q;
  assign res_o.found     = found_q;
  assign res_o.status    = status_q;
  assign res_o.minimum   = links[0].valid ? links[0].entry : '0;
  assign res_o.count     = CountW'(occ_q);
  assign res_o.empty_res = (occ_q == '0);

endmodule

// ===== rtl/core/sle_cell.sv =====
module sle_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sle_pkg::cmd_t  cmd_i,
  input  sle_pkg::link_t left_i,
  input  sle_pkg::link_t right_i,
  output sle_pkg::link_t cell_o
);
  import sle_pkg::*;

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     valid_q, valid_d;
  logic                     place;
  logic                     ge;

  // Compare the stored value against the broadcast key.
  assign place = !valid_q || ($signed(entry_q) > $signed(cmd_i.key));
  assign ge    = valid_q && ($signed(entry_q) >= $signed(cmd_i.key));

  assign cell_o.entry = entry_q;
  assign cell_o.valid = valid_q;
  assign cell_o.place = place;
  assign cell_o.eq    = valid_q && (entry_q == cmd_i.key);

  // Next content: clear, take the key, shift from the left, or shift from the right.
  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (cmd_i.clear) begin
      valid_d = 1'b0;
    end else if (cmd_i.insert) begin
      if (place && !left_i.place) begin
        entry_d = cmd_i.key;
        valid_d = 1'b1;
      end else if (place) begin
        entry_d = left_i.entry;
        valid_d = left_i.valid;
      end
    end else if (cmd_i.pop || (cmd_i.remove && ge)) begin
      entry_d = right_i.entry;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset; it is only read while the valid bit is set.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
